FILE: rtl/core/lfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_pkg
// Beat types and cell command shared by the LFU cache table core and its cells.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [KEY_W-1:0]          lookup_key;
        logic signed [VALUE_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
        logic                      evicted;
    } rsp_t;

    // per-cell update command
    typedef struct packed {
        logic load;   // take the request as a new entry, count 1
        logic shift;  // take the entry of the next cell up
        logic upd;    // hit: bump count, overwrite value on put
        logic put;    // request is a put
    } cell_cmd_t;

endpackage : lfu_pkg
`default_nettype wire

FILE: rtl/core/lfu_cache_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cache_table_core
// Fully associative key-value cache with least-frequently-used replacement,
// built as a row of slot cells that compare in parallel and shift downward.
// ----------------------------------------------------------------------------
// channel | dir | handshake             | beat
// req     | in  | req_valid / req_ready | lfu_pkg::req_t (func, key, value)
// rsp     | out | rsp_valid / rsp_ready | lfu_pkg::rsp_t (hit, value, evicted)
//
// Get, put hit and put into a non-full table: accept, then parallel compare and
// commit. Put miss on a full table: accept, compare, least-count scan, then
// evict and commit; the scan walks the cell row one cell per cycle.
// Reset empties the table at once (fill level to zero); no clearing pass.
// A held result stalls commit of the next beat only; a new beat is accepted
// while the result register still waits.
// ----------------------------------------------------------------------------
module lfu_cache_table_core #(
    parameter int ENTRIES    = 8,
    parameter int COUNT_BITS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire lfu_pkg::req_t  req,
    output logic                rsp_valid,
    input  wire                 rsp_ready,
    output lfu_pkg::rsp_t       rsp
);
    import lfu_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SCAN, S_EVICT} state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  victim_reg, victim_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic [KEY_W-1:0]      key_w   [ENTRIES];
    logic [VALUE_W-1:0]    value_w [ENTRIES];
    logic [COUNT_BITS-1:0] count_w [ENTRIES];
    logic [ENTRIES-1:0]    match_w;
    logic [ENTRIES-1:0]    tok_w;
    logic [COUNT_BITS-1:0] scnt_w  [ENTRIES];
    logic [IDX_W-1:0]      sidx_w  [ENTRIES];
    cell_cmd_t             cmd_w   [ENTRIES];

    logic               slot_free;
    logic               hit_any;
    logic               full;
    logic [VALUE_W-1:0] rd_value;
    logic               hit_do;
    logic               append_do;
    logic               evict_do;
    logic               scan_start;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign hit_any   = |match_w;
    assign full      = (fill_reg == FILL_W'(ENTRIES));
    assign hit_do    = (state_reg == S_LOOK) && hit_any && slot_free;
    assign append_do = (state_reg == S_LOOK) && !hit_any && (req_reg.func == FUNC_PUT)
                       && !full && slot_free;
    assign evict_do  = (state_reg == S_EVICT) && slot_free;
    assign scan_start = (state_reg == S_LOOK) && !hit_any && (req_reg.func == FUNC_PUT)
                        && full;

    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rd_value = rd_value | (value_w[i] & {VALUE_W{match_w[i]}});
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        logic [KEY_W-1:0]      nk;
        logic [VALUE_W-1:0]    nv;
        logic [COUNT_BITS-1:0] nc;
        logic                  ti;
        logic [COUNT_BITS-1:0] ci;
        logic [IDX_W-1:0]      ii;

        if (g == ENTRIES - 1)
        begin : g_top
            assign nk = '0;
            assign nv = '0;
            assign nc = '0;
        end
        else
        begin : g_mid
            assign nk = key_w[g+1];
            assign nv = value_w[g+1];
            assign nc = count_w[g+1];
        end

        if (g == 0)
        begin : g_first
            assign ti = scan_start;
            assign ci = '0;
            assign ii = '0;
        end
        else
        begin : g_rest
            assign ti = tok_w[g-1];
            assign ci = scnt_w[g-1];
            assign ii = sidx_w[g-1];
        end

        always_comb
        begin
            cmd_w[g].put   = (req_reg.func == FUNC_PUT);
            cmd_w[g].upd   = hit_do && match_w[g];
            cmd_w[g].shift = evict_do && (g < ENTRIES - 1) && (IDX_W'(g) >= victim_reg);
            cmd_w[g].load  = (append_do && (fill_reg == FILL_W'(g)))
                             || (evict_do && (g == ENTRIES - 1));
        end

        lfu_cell #(
            .COUNT_BITS (COUNT_BITS),
            .IDX_W      (IDX_W),
            .CELL_IDX   (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd_w[g]),
            .valid       (FILL_W'(g) < fill_reg),
            .req_key     (req_reg.lookup_key),
            .req_value   (req_reg.write_value),
            .nxt_key     (nk),
            .nxt_value   (nv),
            .nxt_count   (nc),
            .key         (key_w[g]),
            .value       (value_w[g]),
            .count       (count_w[g]),
            .match       (match_w[g]),
            .scan_tok_in (ti),
            .scan_cnt_in (ci),
            .scan_idx_in (ii),
            .scan_tok    (tok_w[g]),
            .scan_cnt    (scnt_w[g]),
            .scan_idx    (sidx_w[g])
        );
    end

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        fill_next      = fill_reg;
        victim_next    = victim_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (scan_start)
                begin
                    state_next = S_SCAN;
                end
                else if (slot_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.hit       = hit_any;
                    rsp_next.read_value = (hit_any && (req_reg.func == FUNC_GET))
                                          ? $signed(rd_value) : '0;
                    rsp_next.evicted   = 1'b0;
                    if (append_do)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (tok_w[ENTRIES-1])
                begin
                    victim_next = sidx_w[ENTRIES-1];
                    state_next  = S_EVICT;
                end
            end
            S_EVICT:
            begin
                if (slot_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.hit        = 1'b0;
                    rsp_next.read_value = '0;
                    rsp_next.evicted    = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        victim_reg <= victim_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule : lfu_cache_table_core
`default_nettype wire

FILE: rtl/core/lfu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfu_cell
// One table slot: key, value and use count, local key compare, one stage of
// the least-count scan that runs from cell 0 upward one cell per cycle.
// ----------------------------------------------------------------------------
module lfu_cell #(
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 3,
    parameter int CELL_IDX   = 0
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire lfu_pkg::cell_cmd_t        cmd,
    input  wire                            valid,
    input  wire [lfu_pkg::KEY_W-1:0]       req_key,
    input  wire [lfu_pkg::VALUE_W-1:0]     req_value,
    input  wire [lfu_pkg::KEY_W-1:0]       nxt_key,
    input  wire [lfu_pkg::VALUE_W-1:0]     nxt_value,
    input  wire [COUNT_BITS-1:0]           nxt_count,
    output logic [lfu_pkg::KEY_W-1:0]      key,
    output logic [lfu_pkg::VALUE_W-1:0]    value,
    output logic [COUNT_BITS-1:0]          count,
    output logic                           match,
    input  wire                            scan_tok_in,
    input  wire [COUNT_BITS-1:0]           scan_cnt_in,
    input  wire [IDX_W-1:0]                scan_idx_in,
    output logic                           scan_tok,
    output logic [COUNT_BITS-1:0]          scan_cnt,
    output logic [IDX_W-1:0]               scan_idx
);
    import lfu_pkg::*;

    logic [KEY_W-1:0]      key_reg,   key_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  tok_reg;
    logic [COUNT_BITS-1:0] min_cnt_reg, min_cnt_next;
    logic [IDX_W-1:0]      min_idx_reg, min_idx_next;
    logic                  take_own;

    assign match = valid && (key_reg == req_key);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        count_next = count_reg;
        priority if (cmd.load)
        begin
            key_next   = req_key;
            value_next = req_value;
            count_next = COUNT_BITS'(1);
        end
        else if (cmd.shift)
        begin
            key_next   = nxt_key;
            value_next = nxt_value;
            count_next = nxt_count;
        end
        else if (cmd.upd)
        begin
            if (cmd.put)
            begin
                value_next = req_value;
            end
            if (count_reg != {COUNT_BITS{1'b1}})
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    // strict less keeps the oldest entry on equal counts
    assign take_own = (CELL_IDX == 0) || (count_reg < scan_cnt_in);

    always_comb
    begin
        min_cnt_next = min_cnt_reg;
        min_idx_next = min_idx_reg;
        if (scan_tok_in)
        begin
            min_cnt_next = take_own ? count_reg : scan_cnt_in;
            min_idx_next = take_own ? IDX_W'(CELL_IDX) : scan_idx_in;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        value_reg   <= value_next;
        count_reg   <= count_next;
        min_cnt_reg <= min_cnt_next;
        min_idx_reg <= min_idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= scan_tok_in;
        end
    end

    assign key      = key_reg;
    assign value    = value_reg;
    assign count    = count_reg;
    assign scan_tok = tok_reg;
    assign scan_cnt = min_cnt_reg;
    assign scan_idx = min_idx_reg;

endmodule : lfu_cell
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lfu_cache_table_core. A mirror of the LFU table
// predicts every response beat from the accepted request beats. Directed
// corner beats run first, then random phases over a small key pool with
// idling switched on and off per channel, then a use-count saturation burst.
// ----------------------------------------------------------------------------
module testbench;

    import lfu_pkg::*;

    localparam int ENTRIES    = 8;
    // narrow counts so the saturation burst stays short
    localparam int COUNT_BITS = 4;
    localparam int LATENCY    = ENTRIES + 3;
    localparam int POOL_SIZE  = 12;
    localparam logic [KEY_W-1:0] SAT_KEY = 32'hA5A5_0F0F;

    class lfu_table_mirror;
        logic [KEY_W-1:0]          keys [ENTRIES];
        logic signed [VALUE_W-1:0] vals [ENTRIES];
        logic [COUNT_BITS-1:0]     cnts [ENTRIES];
        int                        fill;
        rsp_t                      pending_rsp[$];
        int                        errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void note_req(req_t r);
            rsp_t e;
            int   pos;
            int   victim;
            e   = '0;
            pos = -1;
            for (int i = 0; i < fill; i++)
                if (pos < 0 && keys[i] == r.lookup_key)
                    pos = i;
            if (pos >= 0)
            begin
                e.hit = 1'b1;
                if (r.func == FUNC_GET)
                    e.read_value = vals[pos];
                else
                    vals[pos] = r.write_value;
                if (cnts[pos] != {COUNT_BITS{1'b1}})
                    cnts[pos] = cnts[pos] + 1'b1;
            end
            else if (r.func == FUNC_PUT)
            begin
                if (fill >= ENTRIES)
                begin
                    victim = 0;
                    for (int i = 1; i < fill; i++)
                        if (cnts[i] < cnts[victim])
                            victim = i;
                    for (int i = victim; i < ENTRIES - 1; i++)
                    begin
                        keys[i] = keys[i+1];
                        vals[i] = vals[i+1];
                        cnts[i] = cnts[i+1];
                    end
                    fill      = ENTRIES - 1;
                    e.evicted = 1'b1;
                end
                keys[fill] = r.lookup_key;
                vals[fill] = r.write_value;
                cnts[fill] = 1;
                fill++;
            end
            pending_rsp.push_back(e);
        endfunction

        function void check_rsp(rsp_t got);
            rsp_t e;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response beat with none pending: hit=%0b value=%0d evicted=%0b",
                         $time, got.hit, got.read_value, got.evicted);
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (got.hit !== e.hit)
            begin
                $display("%0t: hit mismatch: expected %0b, actual %0b", $time, e.hit, got.hit);
                errors++;
            end
            if (got.read_value !== e.read_value)
            begin
                $display("%0t: read_value mismatch: expected %0d, actual %0d",
                         $time, e.read_value, got.read_value);
                errors++;
            end
            if (got.evicted !== e.evicted)
            begin
                $display("%0t: evicted mismatch: expected %0b, actual %0b",
                         $time, e.evicted, got.evicted);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    lfu_table_mirror  mirror;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    bit               src_idle_en;
    bit               snk_idle_en;
    int               snk_stall;

    lfu_cache_table_core #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic req_t mk_req(logic func, logic [KEY_W-1:0] key,
                                    logic signed [VALUE_W-1:0] value);
        req_t r;
        r.func        = func;
        r.lookup_key  = key;
        r.write_value = value;
        return r;
    endfunction

    // response side: random back-pressure
    always @(negedge clk)
    begin
        if (snk_stall > 0)
        begin
            rsp_ready <= 1'b0;
            snk_stall <= snk_stall - 1;
        end
        else
        begin
            rsp_ready <= 1'b1;
            if (snk_idle_en && $urandom_range(0, 99) < 40)
                snk_stall <= pick_gap();
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            mirror.check_rsp(rsp);

    task automatic send_req(input req_t r);
        int gap;
        gap = src_idle_en ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
        mirror.note_req(r);
    endtask

    // hold the request side until every pending response beat is back
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (mirror.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send_req(mk_req(FUNC_GET, 32'h0000_0000, 32'sh1234_5678));
        send_req(mk_req(FUNC_PUT, 32'h0000_0000, 32'sh7FFF_FFFF));
        send_req(mk_req(FUNC_PUT, 32'hFFFF_FFFF, 32'sh8000_0000));
        send_req(mk_req(FUNC_GET, 32'h0000_0000, 32'sh0000_0000));
        send_req(mk_req(FUNC_GET, 32'hFFFF_FFFF, 32'shFFFF_FFFF));
        send_req(mk_req(FUNC_PUT, 32'h0000_0000, -32'sd1));
        send_req(mk_req(FUNC_GET, 32'h0000_0000, 32'sh5555_5555));
        for (int i = 1; i <= 6; i++)
            send_req(mk_req(FUNC_PUT, 32'h1 << (i * 5), $signed(i * 32'h1111_1111)));
        send_req(mk_req(FUNC_GET, 32'h0000_0020, 32'sh0));
        send_req(mk_req(FUNC_PUT, 32'hAAAA_AAAA, 32'shAAAA_AAAA));
        send_req(mk_req(FUNC_GET, 32'h0000_0400, 32'sh0));
        send_req(mk_req(FUNC_PUT, 32'h5555_5555, 32'sh5555_5555));
        send_req(mk_req(FUNC_PUT, 32'h0000_0020, 32'sh0101_0101));
        send_req(mk_req(FUNC_GET, 32'hFFFF_FFFF, 32'sh0));
        send_req(mk_req(FUNC_GET, 32'hAAAA_AAAA, 32'sh0));
        send_req(mk_req(FUNC_GET, 32'h1234_5678, 32'sh0));
    endtask

    task automatic run_random(input int n_items, input int get_pct);
        req_t r;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        for (int i = 0; i < n_items; i++)
        begin
            r.func        = ($urandom_range(0, 99) < get_pct) ? FUNC_GET : FUNC_PUT;
            r.lookup_key  = ($urandom_range(0, 9) == 0) ? $urandom()
                                                        : key_pool[$urandom_range(0, POOL_SIZE - 1)];
            r.write_value = $urandom();
            send_req(r);
        end
    endtask

    // drive one key past the count ceiling, then force evictions around it
    task automatic run_saturation();
        send_req(mk_req(FUNC_PUT, SAT_KEY, 32'sh0BAD_F00D));
        repeat ((1 << COUNT_BITS) + 4)
            send_req(mk_req(FUNC_GET, SAT_KEY, 32'sh0));
        repeat (ENTRIES + 2)
            send_req(mk_req(FUNC_PUT, $urandom(), $urandom()));
        send_req(mk_req(FUNC_GET, SAT_KEY, 32'sh0));
    endtask

    initial
    begin
        mirror      = new();
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        rsp_ready   = 1'b0;
        snk_stall   = 0;
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        drain();

        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        run_random(170, 50);
        drain();

        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        run_random(170, 30);
        drain();

        src_idle_en = 1'b1;
        snk_idle_en = 1'b0;
        run_random(170, 70);
        drain();

        src_idle_en = 1'b0;
        snk_idle_en = 1'b1;
        run_random(170, 50);
        drain();

        snk_idle_en = 1'b0;
        run_saturation();
        drain();

        repeat (LATENCY)
            @(posedge clk);
        if (mirror.errors == 0 && mirror.pending_rsp.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
